### rtl/cbmsi_pkg.sv
// Shared types and constants for the cartridge bank mapper with scanline interrupt.
// Holds the request structs, command codes, register indexes and decode addresses.
// Depends on nothing.
`timescale 1ns / 1ps

package cbmsi_pkg;

    localparam int VISIBLE_LINES_DEFAULT = 240;
    localparam int IRQ_LINES_DEFAULT     = 8;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 8;

    localparam logic [CFG_INDEX_W-1:0] CFG_PRG_BANK_MASK = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_CHR_BANK_MASK = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_CHR_PRESENT   = 2'd2;

    localparam logic [15:0] DEC_MASK       = 16'hF003;
    localparam logic [15:0] DEC_CHR_MASK   = 16'hFFFC;
    localparam logic [15:0] DEC_CHR_BASE   = 16'h6000;
    localparam logic [15:0] DEC_PRG_LOW    = 16'h7000;
    localparam logic [15:0] DEC_PRG_HIGH   = 16'h7001;
    localparam logic [15:0] DEC_IRQ_OFF    = 16'h7002;
    localparam logic [15:0] DEC_IRQ_ON     = 16'h7003;

    localparam logic [7:0] PRG_FIXED_C000 = 8'd254;
    localparam logic [7:0] PRG_FIXED_E000 = 8'd255;
    localparam logic [7:0] COUNT_MAX      = 8'd255;

    typedef enum logic [1:0] {
        CMD_REG_WRITE = 2'd0,
        CMD_TICK      = 2'd1,
        CMD_PRG_ADDR  = 2'd2,
        CMD_CHR_ADDR  = 2'd3
    } cmd_t;

    typedef struct packed {
        cmd_t        command;
        logic [15:0] bus_address;
        logic [7:0]  write_data;
        logic [8:0]  line_number;
        logic        display_on;
    } in_req_t;

    typedef struct packed {
        logic [20:0] rom_address;
        logic        irq_line;
    } out_req_t;

endpackage

### rtl/cartridge_bank_mapper_scanline_irq.sv
// Top level of the cartridge bank mapper with scanline interrupt counter.
// A request that is accepted is held in the input register, and its result is
// loaded into the result register when the output register is empty or being read.
// Throughput: one request per cycle while out_ready does not stall the output.
// Reset clears the handshake state, sets the bank registers to their power-up
// banks, disables the counter and restores the configuration defaults.
`timescale 1ns / 1ps

module cartridge_bank_mapper_scanline_irq #(
    parameter int VISIBLE_LINES = cbmsi_pkg::VISIBLE_LINES_DEFAULT,
    parameter int IRQ_LINES     = cbmsi_pkg::IRQ_LINES_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  cbmsi_pkg::in_req_t                  in_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output cbmsi_pkg::out_req_t                 out_data,
    input  logic                                cfg_write,
    input  logic [cbmsi_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [cbmsi_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import cbmsi_pkg::*;

    localparam logic [8:0] VISIBLE_LIMIT = 9'(VISIBLE_LINES);
    localparam logic [7:0] IRQ_LIMIT     = 8'(IRQ_LINES);

    logic [7:0] prg_bank_mask_reg;
    logic [7:0] chr_bank_mask_reg;
    logic       chr_present_reg;

    logic       in_valid_reg;
    in_req_t    in_req_reg;
    logic       out_valid_reg;
    out_req_t   out_req_reg;
    out_req_t   out_req_next;

    logic [7:0] chr_banks_reg [4];
    logic [7:0] chr_banks_next [4];
    logic [7:0] prg_bank_low_reg;
    logic [7:0] prg_bank_low_next;
    logic [7:0] prg_bank_high_reg;
    logic [7:0] prg_bank_high_next;
    logic       count_enable_reg;
    logic       count_enable_next;
    logic [7:0] line_count_reg;
    logic [7:0] line_count_next;
    logic       irq_pending_reg;
    logic       irq_pending_next;

    logic        advance;
    logic [15:0] dec_address;
    logic [7:0]  prg_bank;
    logic [7:0]  chr_bank;
    logic [12:0] chr_offset;

    assign advance   = !out_valid_reg || out_ready;
    assign in_ready  = !in_valid_reg || advance;
    assign out_valid = out_valid_reg;
    assign out_data  = out_req_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            prg_bank_mask_reg <= 8'hFF;
            chr_bank_mask_reg <= 8'hFF;
            chr_present_reg   <= 1'b1;
        end else if (cfg_write) begin
            unique case (cfg_index)
                CFG_PRG_BANK_MASK: prg_bank_mask_reg <= cfg_data;
                CFG_CHR_BANK_MASK: chr_bank_mask_reg <= cfg_data;
                CFG_CHR_PRESENT:   chr_present_reg   <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_valid_reg <= 1'b0;
        end else if (in_ready) begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk) begin
        if (in_ready && in_valid) begin
            in_req_reg <= in_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk) begin
        if (advance && in_valid_reg) begin
            out_req_reg <= out_req_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            chr_banks_reg[0]  <= 8'd0;
            chr_banks_reg[1]  <= 8'd1;
            chr_banks_reg[2]  <= 8'd2;
            chr_banks_reg[3]  <= 8'd3;
            prg_bank_low_reg  <= PRG_FIXED_C000;
            prg_bank_high_reg <= PRG_FIXED_E000;
            count_enable_reg  <= 1'b0;
            line_count_reg    <= 8'd0;
            irq_pending_reg   <= 1'b0;
        end else if (advance && in_valid_reg) begin
            chr_banks_reg     <= chr_banks_next;
            prg_bank_low_reg  <= prg_bank_low_next;
            prg_bank_high_reg <= prg_bank_high_next;
            count_enable_reg  <= count_enable_next;
            line_count_reg    <= line_count_next;
            irq_pending_reg   <= irq_pending_next;
        end
    end

    assign dec_address = in_req_reg.bus_address & DEC_MASK;
    assign chr_offset  = in_req_reg.bus_address[12:0];
    assign chr_bank    = chr_banks_reg[chr_offset[12:11]] & chr_bank_mask_reg;

    always_comb begin
        unique case (in_req_reg.bus_address[14:13])
            2'd0:    prg_bank = prg_bank_low_reg;
            2'd1:    prg_bank = prg_bank_high_reg;
            2'd2:    prg_bank = PRG_FIXED_C000;
            default: prg_bank = PRG_FIXED_E000;
        endcase
        prg_bank = prg_bank & prg_bank_mask_reg;
    end

    always_comb begin
        chr_banks_next     = chr_banks_reg;
        prg_bank_low_next  = prg_bank_low_reg;
        prg_bank_high_next = prg_bank_high_reg;
        count_enable_next  = count_enable_reg;
        line_count_next    = line_count_reg;
        irq_pending_next   = irq_pending_reg;
        out_req_next.rom_address = 21'd0;

        unique case (in_req_reg.command)
            CMD_REG_WRITE: begin
                priority if ((dec_address & DEC_CHR_MASK) == DEC_CHR_BASE) begin
                    if (chr_present_reg) begin
                        chr_banks_next[dec_address[1:0]] = in_req_reg.write_data;
                    end
                end else if (dec_address == DEC_PRG_LOW) begin
                    prg_bank_low_next = in_req_reg.write_data;
                end else if (dec_address == DEC_PRG_HIGH) begin
                    prg_bank_high_next = in_req_reg.write_data;
                end else if (dec_address == DEC_IRQ_OFF) begin
                    count_enable_next = 1'b0;
                    line_count_next   = 8'd0;
                    irq_pending_next  = 1'b0;
                end else if (dec_address == DEC_IRQ_ON) begin
                    count_enable_next = 1'b1;
                end else begin
                end
            end
            CMD_TICK: begin
                if (in_req_reg.line_number < VISIBLE_LIMIT && in_req_reg.display_on) begin
                    if (count_enable_reg && line_count_reg != COUNT_MAX) begin
                        line_count_next = line_count_reg + 8'd1;
                    end
                    if (line_count_next >= IRQ_LIMIT) begin
                        irq_pending_next = 1'b1;
                    end
                end
            end
            CMD_PRG_ADDR: begin
                if (in_req_reg.bus_address[15]) begin
                    out_req_next.rom_address = {prg_bank, in_req_reg.bus_address[12:0]};
                end
            end
            CMD_CHR_ADDR: begin
                if (chr_present_reg) begin
                    out_req_next.rom_address = {2'b00, chr_bank, chr_offset[10:0]};
                end else begin
                    out_req_next.rom_address = {8'd0, chr_offset};
                end
            end
        endcase

        out_req_next.irq_line = irq_pending_next;
    end

endmodule

### sim/cartridge_bank_mapper_scanline_irq_tb.sv
// Self-checking testbench for the cartridge bank mapper with scanline interrupt.
// A directed table and random phases run through the request and result ports.
// Depends on rtl/cbmsi_pkg.sv and rtl/cartridge_bank_mapper_scanline_irq.sv.
`timescale 1ns / 1ps

module cartridge_bank_mapper_scanline_irq_tb;
    import cbmsi_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 500000;

    typedef struct {
        in_req_t  req;
        bit       typed;
        out_req_t want;
    } table_row_t;

    logic     clk;
    logic     rst_n;
    logic     in_valid;
    logic     in_ready;
    in_req_t  in_data;
    logic     out_valid;
    logic     out_ready;
    out_req_t out_data;
    logic     cfg_write;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    logic [7:0] prg_mask_cfg;
    logic [7:0] chr_mask_cfg;
    logic       chr_rom_cfg;
    logic [7:0] chr_bank [4];
    logic [7:0] prg_bank_lo;
    logic [7:0] prg_bank_hi;
    logic       counting;
    logic [7:0] lines_seen;
    logic       irq_latched;

    out_req_t    mapper_results_q[$];
    table_row_t  directed_rows[$];
    int unsigned mismatch_count;
    int unsigned cycle_count;
    bit          calm;

    cartridge_bank_mapper_scanline_irq dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #10 clk = ~clk;

    function automatic out_req_t mapper_predict(in_req_t req);
        logic [15:0] dec;
        logic [7:0]  bank;
        logic [12:0] low13;
        out_req_t    res;
        res = '0;
        case (req.command)
            CMD_REG_WRITE:
            begin
                dec = req.bus_address & DEC_MASK;
                if ((dec & DEC_CHR_MASK) == DEC_CHR_BASE)
                begin
                    if (chr_rom_cfg)
                        chr_bank[dec[1:0]] = req.write_data;
                end
                else if (dec == DEC_PRG_LOW)
                    prg_bank_lo = req.write_data;
                else if (dec == DEC_PRG_HIGH)
                    prg_bank_hi = req.write_data;
                else if (dec == DEC_IRQ_OFF)
                begin
                    counting    = 1'b0;
                    lines_seen  = '0;
                    irq_latched = 1'b0;
                end
                else if (dec == DEC_IRQ_ON)
                    counting = 1'b1;
            end
            CMD_TICK:
            begin
                if (req.line_number < VISIBLE_LINES_DEFAULT && req.display_on)
                begin
                    if (counting && lines_seen < COUNT_MAX)
                        lines_seen = lines_seen + 8'd1;
                    if (lines_seen >= IRQ_LINES_DEFAULT)
                        irq_latched = 1'b1;
                end
            end
            CMD_PRG_ADDR:
            begin
                if (req.bus_address[15])
                begin
                    case (req.bus_address[14:13])
                        2'd0:    bank = prg_bank_lo;
                        2'd1:    bank = prg_bank_hi;
                        2'd2:    bank = PRG_FIXED_C000;
                        default: bank = PRG_FIXED_E000;
                    endcase
                    bank = bank & prg_mask_cfg;
                    res.rom_address = {bank, req.bus_address[12:0]};
                end
            end
            default:
            begin
                low13 = req.bus_address[12:0];
                if (!chr_rom_cfg)
                    res.rom_address = {8'd0, low13};
                else
                begin
                    bank = chr_bank[low13[12:11]] & chr_mask_cfg;
                    res.rom_address = {2'd0, bank, low13[10:0]};
                end
            end
        endcase
        res.irq_line = irq_latched;
        return res;
    endfunction

    function automatic void add_row(cmd_t cmd, logic [15:0] addr, logic [7:0] data,
                                    logic [8:0] line, logic disp, bit typed,
                                    logic [20:0] rom, logic irq);
        table_row_t row;
        row.req.command     = cmd;
        row.req.bus_address = addr;
        row.req.write_data  = data;
        row.req.line_number = line;
        row.req.display_on  = disp;
        row.typed           = typed;
        row.want.rom_address = rom;
        row.want.irq_line    = irq;
        directed_rows.push_back(row);
    endfunction

    function automatic in_req_t make_request(int tick_pct, int clear_odds);
        in_req_t     r;
        int          pick;
        logic [15:0] target;
        r.command     = CMD_PRG_ADDR;
        r.bus_address = 16'($urandom_range(0, 65535));
        r.write_data  = 8'($urandom_range(0, 255));
        r.line_number = 9'($urandom_range(0, 511));
        r.display_on  = 1'($urandom_range(0, 1));
        pick = $urandom_range(0, 99);
        if (pick < tick_pct)
        begin
            r.command = CMD_TICK;
            if ($urandom_range(0, 6) != 0)
            begin
                r.line_number = 9'($urandom_range(0, VISIBLE_LINES_DEFAULT - 1));
                r.display_on  = 1'b1;
            end
        end
        else if (pick < tick_pct + (100 - tick_pct) / 3)
            r.command = CMD_PRG_ADDR;
        else if (pick < tick_pct + 2 * (100 - tick_pct) / 3)
            r.command = CMD_CHR_ADDR;
        else
        begin
            r.command = CMD_REG_WRITE;
            if ($urandom_range(0, clear_odds) == 0)
                target = DEC_IRQ_OFF;
            else
            begin
                case ($urandom_range(0, 7))
                    0, 1, 2, 3: target = DEC_CHR_BASE | 16'($urandom_range(0, 3));
                    4:          target = DEC_PRG_LOW;
                    5:          target = DEC_PRG_HIGH;
                    6:          target = DEC_IRQ_ON;
                    default:    target = r.bus_address & DEC_MASK;
                endcase
            end
            r.bus_address = (r.bus_address & ~DEC_MASK) | target;
        end
        return r;
    endfunction

    task automatic send(in_req_t req, bit typed, out_req_t want);
        out_req_t pred;
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        do @(posedge clk); while (!in_ready);
        pred = mapper_predict(req);
        mapper_results_q.push_back(typed ? want : pred);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (mapper_results_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // The block is idle here, so the new settings apply to every later request.
    task automatic run_phase(logic [7:0] prg_mask, logic [7:0] chr_mask, logic present,
                             int count, int tick_pct, int clear_odds, bit quiet);
        wait_drained();
        cfg_write <= 1'b1;
        cfg_index <= CFG_PRG_BANK_MASK;
        cfg_data  <= prg_mask;
        @(posedge clk);
        cfg_index <= CFG_CHR_BANK_MASK;
        cfg_data  <= chr_mask;
        @(posedge clk);
        cfg_index <= CFG_CHR_PRESENT;
        cfg_data  <= {7'd0, present};
        @(posedge clk);
        cfg_write    <= 1'b0;
        prg_mask_cfg = prg_mask;
        chr_mask_cfg = chr_mask;
        chr_rom_cfg  = present;
        calm = quiet;
        repeat (count)
            send(make_request(tick_pct, clear_odds), 1'b0, '0);
    endtask

    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!calm && $urandom_range(0, 9) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : check_results
        out_req_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (mapper_results_q.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, got %h", $time, out_data);
                mismatch_count++;
            end
            else
            begin
                want = mapper_results_q.pop_front();
                if (out_data.rom_address !== want.rom_address)
                begin
                    $display("%0t: rom_address mismatch, expected %h, got %h",
                             $time, want.rom_address, out_data.rom_address);
                    mismatch_count++;
                end
                if (out_data.irq_line !== want.irq_line)
                begin
                    $display("%0t: irq_line mismatch, expected %b, got %b",
                             $time, want.irq_line, out_data.irq_line);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        logic [7:0] prg_mask;
        logic [7:0] chr_mask;
        clk = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        mismatch_count = 0;
        cycle_count = 0;
        calm = 1'b0;
        prg_mask_cfg = 8'd255;
        chr_mask_cfg = 8'd255;
        chr_rom_cfg = 1'b1;
        chr_bank[0] = 8'd0;
        chr_bank[1] = 8'd1;
        chr_bank[2] = 8'd2;
        chr_bank[3] = 8'd3;
        prg_bank_lo = PRG_FIXED_C000;
        prg_bank_hi = PRG_FIXED_E000;
        counting = 1'b0;
        lines_seen = '0;
        irq_latched = 1'b0;

        // Program reads below the cartridge window and the bank edges after reset.
        add_row(CMD_PRG_ADDR, 16'h0000, 8'h00, 9'd0, 1'b0, 1, 21'h000000, 1'b0);
        add_row(CMD_PRG_ADDR, 16'h7FFF, 8'h00, 9'd0, 1'b0, 1, 21'h000000, 1'b0);
        add_row(CMD_PRG_ADDR, 16'h8000, 8'h00, 9'd0, 1'b0, 1, 21'h1FC000, 1'b0);
        add_row(CMD_PRG_ADDR, 16'hA000, 8'h00, 9'd0, 1'b0, 1, 21'h1FE000, 1'b0);
        add_row(CMD_PRG_ADDR, 16'hC123, 8'h00, 9'd0, 1'b0, 1, 21'h1FC123, 1'b0);
        add_row(CMD_PRG_ADDR, 16'hFFFF, 8'hFF, 9'd511, 1'b1, 1, 21'h1FFFFF, 1'b0);
        // Pattern reads, including an address above the pattern space.
        add_row(CMD_CHR_ADDR, 16'h0000, 8'h00, 9'd0, 1'b0, 1, 21'h000000, 1'b0);
        add_row(CMD_CHR_ADDR, 16'h1FFF, 8'h00, 9'd0, 1'b0, 1, 21'h001FFF, 1'b0);
        add_row(CMD_CHR_ADDR, 16'hFFFF, 8'h00, 9'd0, 1'b0, 1, 21'h001FFF, 1'b0);
        // Bank writes, an undecoded write and an aliased program bank write.
        add_row(CMD_REG_WRITE, 16'h6000, 8'hFF, 9'd0, 1'b0, 1, 21'h000000, 1'b0);
        add_row(CMD_REG_WRITE, 16'h6003, 8'h80, 9'd0, 1'b0, 1, 21'h000000, 1'b0);
        add_row(CMD_REG_WRITE, 16'hF002, 8'h55, 9'd0, 1'b0, 1, 21'h000000, 1'b0);
        add_row(CMD_REG_WRITE, 16'h7FF0, 8'h00, 9'd0, 1'b0, 1, 21'h000000, 1'b0);
        add_row(CMD_REG_WRITE, 16'h7001, 8'h01, 9'd0, 1'b0, 1, 21'h000000, 1'b0);
        add_row(CMD_CHR_ADDR, 16'h0400, 8'h00, 9'd0, 1'b0, 0, '0, 1'b0);
        add_row(CMD_CHR_ADDR, 16'h1C00, 8'h00, 9'd0, 1'b0, 0, '0, 1'b0);
        add_row(CMD_PRG_ADDR, 16'h9FFF, 8'h00, 9'd0, 1'b0, 0, '0, 1'b0);
        add_row(CMD_PRG_ADDR, 16'hBFFF, 8'h00, 9'd0, 1'b0, 0, '0, 1'b0);
        // Counter enable, ticks on and off the visible area, then a clear.
        add_row(CMD_REG_WRITE, 16'h7003, 8'h00, 9'd0, 1'b0, 1, 21'h000000, 1'b0);
        add_row(CMD_TICK, 16'h0000, 8'h00, 9'd239, 1'b1, 0, '0, 1'b0);
        add_row(CMD_TICK, 16'h0000, 8'h00, 9'd240, 1'b1, 0, '0, 1'b0);
        add_row(CMD_TICK, 16'h0000, 8'h00, 9'd511, 1'b0, 0, '0, 1'b0);
        add_row(CMD_TICK, 16'h0000, 8'h00, 9'd0, 1'b0, 0, '0, 1'b0);
        add_row(CMD_REG_WRITE, 16'h7002, 8'h00, 9'd0, 1'b0, 1, 21'h000000, 1'b0);
        add_row(CMD_TICK, 16'h0000, 8'h00, 9'd0, 1'b1, 0, '0, 1'b0);

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);

        run_phase(8'd255, 8'd255, 1'b1, 300, 35, 20, 1'b0);
        run_phase(8'd1, 8'd0, 1'b0, 250, 35, 20, 1'b0);
        run_phase(8'd1, 8'd0, 1'b1, 250, 35, 20, 1'b0);
        // Long stretch of rendered lines with rare clears drives the counter toward saturation.
        run_phase(8'h3F, 8'hFF, 1'b1, 450, 80, 100000, 1'b0);
        run_phase(8'h0F, 8'h07, 1'b1, 250, 35, 20, 1'b0);
        prg_mask = 8'((1 << $urandom_range(1, 8)) - 1);
        chr_mask = 8'((1 << $urandom_range(0, 8)) - 1);
        run_phase(prg_mask, chr_mask, 1'($urandom_range(0, 1)), 250, 35, 20, 1'b0);
        prg_mask = 8'((1 << $urandom_range(1, 8)) - 1);
        chr_mask = 8'((1 << $urandom_range(0, 8)) - 1);
        run_phase(prg_mask, chr_mask, 1'b1, 300, 35, 20, 1'b1);

        wait_drained();
        repeat (8) @(posedge clk);
        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
